@@ hw/rtl/jjsl_pkg.sv @@
package jjsl_pkg;

  localparam int JOINTS   = 6;
  localparam int LANES    = 8;
  localparam int SPEED_W  = 28;
  localparam int DIST_W   = 35;

  // joint served by each lane; even lanes look toward the maximum, odd toward the minimum
  localparam int LANE_JOINT [LANES] = '{0, 0, 1, 1, 2, 2, 4, 4};

  typedef struct packed {
    logic               done;
    logic [SPEED_W-1:0] speed;
  } lane_stat_t;

endpackage

@@ hw/rtl/jjsl_lane.sv @@
module jjsl_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [jjsl_pkg::DIST_W-1:0]  dist_in,
  input  logic [15:0]                         acc,
  input  logic [15:0]                         vel,
  output jjsl_pkg::lane_stat_t                stat
);
  import jjsl_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_MUL, L_CMP, L_SQRT} lstate_t;

  lstate_t             state_r;
  logic signed [DIST_W-1:0] d_r;
  logic [15:0]         acc_r;
  logic [15:0]         vel_r;
  logic [62:0]         prod_r;
  logic [55:0]         vv_r;
  logic [55:0]         rem_r;
  logic [55:0]         root_r;
  logic [55:0]         bit_r;
  logic                done_r;
  logic [SPEED_W-1:0]  speed_r;

  logic [50:0]         p2;
  logic [27:0]         vsh;
  logic [55:0]         trial;
  logic [55:0]         rem_nxt;
  logic [55:0]         root_nxt;

  always_comb begin
    p2    = {acc_r, 1'b0} * d_r[33:0];
    vsh   = {vel_r, 12'b0};
    trial = root_r + bit_r;
    if (rem_r >= trial) begin
      rem_nxt  = rem_r - trial;
      root_nxt = (root_r >> 1) + bit_r;
    end else begin
      rem_nxt  = rem_r;
      root_nxt = root_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start) begin
            d_r     <= dist_in;
            acc_r   <= acc;
            vel_r   <= vel;
            done_r  <= 1'b0;
            state_r <= L_MUL;
          end
        end
        L_MUL: begin
          if (d_r < 0) begin
            speed_r <= '0;
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end else begin
            prod_r  <= {p2, 12'b0};
            vv_r    <= vsh * vsh;
            state_r <= L_CMP;
          end
        end
        L_CMP: begin
          if (prod_r > {7'b0, vv_r}) begin
            speed_r <= vsh;
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end else begin
            rem_r   <= prod_r[55:0];
            root_r  <= '0;
            bit_r   <= 56'h1 << 54;
            state_r <= L_SQRT;
          end
        end
        L_SQRT: begin
          // one result bit per cycle
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          if (bit_r == 56'h1) begin
            speed_r <= root_nxt[SPEED_W-1:0];
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign stat.done  = done_r;
  assign stat.speed = speed_r;

endmodule

@@ hw/rtl/joint_jog_soft_limiter_top.sv @@
// Joint jog soft limiter. Each accepted item (one servo tick) yields one result
// item of six commanded positions and a clamped flag. Eight braking-speed lanes
// run side by side, each finding floor(sqrt(2*a*d << 12)) by a bit-serial root
// that produces one bit per cycle; a lane skips its root when its distance is
// negative or its speed is capped. A short chain of ramp, integrate and clamp
// steps follows. One item is in work at a time; a finished result waits in the
// output register while the next item is taken. Configuration is to be written
// only while idle; the block itself does not enforce this.
module joint_jog_soft_limiter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_feedback_first,
  input  logic signed [31:0] in_feedback_second,
  input  logic signed [31:0] in_feedback_third,
  input  logic signed [31:0] in_feedback_fourth,
  input  logic signed [31:0] in_feedback_fifth,
  input  logic signed [31:0] in_feedback_sixth,
  input  logic [2:0]         in_jog_axis,
  input  logic signed [15:0] in_jog_speed,
  input  logic [15:0]        in_override_fraction,
  input  logic [1:0]         in_mode_select,
  input  logic               in_resync,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_command_first,
  output logic signed [31:0] out_command_second,
  output logic signed [31:0] out_command_third,
  output logic signed [31:0] out_command_fourth,
  output logic signed [31:0] out_command_fifth,
  output logic signed [31:0] out_command_sixth,
  output logic               out_clamped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import jjsl_pkg::*;

  localparam logic [1:0]  MODE_NONE  = 2'd0;
  localparam logic [1:0]  MODE_JOINT = 2'd2;
  localparam logic [2:0]  REG_TICK   = 3'd6;
  localparam logic [47:0] TICK_RESET = 48'd140737492650295;
  localparam logic [15:0] OVR_MIN    = 16'd33;
  localparam logic [15:0] OVR_MAX    = 16'd32768;
  localparam logic signed [33:0] CLAMP_TOL = 34'sd268435;

  typedef enum logic [2:0] {S_IDLE, S_LANE, S_M1, S_M2, S_RAMP, S_MOVE, S_ADD, S_CLAMP} state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [63:0]         lim_r [JOINTS];
  logic [47:0]         tick_r;

  state_t              state_r;
  logic signed [31:0]  cmd_r [JOINTS];
  logic signed [31:0]  rv_r;
  logic                wjm_r;
  logic signed [31:0]  fb_r [JOINTS];
  logic [2:0]          axis_r;
  logic signed [15:0]  jog_r;
  logic [15:0]         ovr_r;
  logic [1:0]          mode_r;
  logic                rs_r;
  logic                start_r;
  logic signed [32:0]  m1_r;
  logic [31:0]         m2_r;
  logic [47:0]         accdt_r;
  logic signed [65:0]  p_r;
  logic signed [31:0]  vcap_r;
  logic signed [64:0]  mv_r;
  logic                out_valid_r;
  logic signed [31:0]  out_cmd_r [JOINTS];
  logic                out_clamped_r;

  logic signed [DIST_W-1:0] d_lane [LANES];
  lane_stat_t               lstat  [LANES];
  logic [LANES-1:0]         ldone;

  logic [31:0]         dt;
  logic [15:0]         scale;
  logic [15:0]         ovr_c;
  logic                jogging;
  logic [15:0]         acc_j;
  logic [15:0]         vel_j;
  logic [SPEED_W-1:0]  pos_ok;
  logic [SPEED_W-1:0]  neg_ok;
  logic signed [34:0]  want;
  logic signed [34:0]  diff;
  logic signed [34:0]  stp;
  logic signed [34:0]  vraw;
  logic signed [31:0]  rv_nxt;
  logic signed [31:0]  vcap_nxt;
  logic signed [31:0]  move_nxt;
  logic signed [31:0]  ccl [JOINTS];
  logic                clamp_any;

  assign dt    = tick_r[31:0];
  assign scale = tick_r[47:32];
  assign jogging = (mode_r == MODE_JOINT) && (axis_r < 3'(JOINTS));
  assign acc_j = lim_r[axis_r][63:48];
  assign vel_j = lim_r[axis_r][47:32];

  always_comb begin
    if (in_override_fraction < OVR_MIN) ovr_c = OVR_MIN;
    else if (in_override_fraction > OVR_MAX) ovr_c = OVR_MAX;
    else ovr_c = in_override_fraction;
  end

  // distances to the limits from the previous commands
  always_comb begin
    logic signed [DIST_W-1:0] c0, c1, c2, c4, sum, mn [JOINTS], mx [JOINTS];
    logic signed [DIST_W-1:0] a, b;
    for (int i = 0; i < JOINTS; i++) begin
      mn[i] = {{3{lim_r[i][15]}}, lim_r[i][15:0], 16'b0};
      mx[i] = {{3{lim_r[i][31]}}, lim_r[i][31:16], 16'b0};
    end
    c0  = DIST_W'(cmd_r[0]);
    c1  = DIST_W'(cmd_r[1]);
    c2  = DIST_W'(cmd_r[2]);
    c4  = DIST_W'(cmd_r[4]);
    sum = c1 + c2;
    d_lane[0] = mx[0] - c0;
    d_lane[1] = c0 - mn[0];
    a = mx[1] - c1;
    b = mx[2] - sum;
    d_lane[2] = (a < b) ? a : b;
    a = c1 - mn[1];
    b = sum - mn[2];
    d_lane[3] = (a < b) ? a : b;
    d_lane[4] = mx[2] - sum;
    d_lane[5] = sum - mn[2];
    d_lane[6] = mx[4] - c4;
    d_lane[7] = c4 - mn[4];
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    jjsl_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (start_r),
      .dist_in (d_lane[k]),
      .acc     (lim_r[LANE_JOINT[k]][63:48]),
      .vel     (lim_r[LANE_JOINT[k]][47:32]),
      .stat    (lstat[k])
    );
    assign ldone[k] = lstat[k].done;
  end

  // merge: pick the jogged joint's allowed speeds
  always_comb begin
    case (axis_r)
      3'd0: begin pos_ok = lstat[0].speed; neg_ok = lstat[1].speed; end
      3'd1: begin pos_ok = lstat[2].speed; neg_ok = lstat[3].speed; end
      3'd2: begin pos_ok = lstat[4].speed; neg_ok = lstat[5].speed; end
      3'd4: begin pos_ok = lstat[6].speed; neg_ok = lstat[7].speed; end
      default: begin pos_ok = {vel_j, 12'b0}; neg_ok = {vel_j, 12'b0}; end
    endcase
  end

  // velocity ramp and cap
  always_comb begin
    want = 35'($signed(p_r[65:33]));
    stp  = {3'b0, accdt_r[47:16]};
    diff = want - 35'(rv_r);
    if (diff > stp) vraw = 35'(rv_r) + stp;
    else if (diff < -stp) vraw = 35'(rv_r) - stp;
    else vraw = want;
    rv_nxt   = sat32(40'(vraw));
    vcap_nxt = rv_nxt;
    if (rv_nxt < 0) begin
      if (rv_nxt < -$signed({4'b0, neg_ok})) vcap_nxt = -$signed({4'b0, neg_ok});
    end else begin
      if (rv_nxt > $signed({4'b0, pos_ok})) vcap_nxt = $signed({4'b0, pos_ok});
    end
    move_nxt = sat32(40'(cmd_r[axis_r]) + 40'($signed(mv_r[64:28])));
  end

  // clamp; joint three against the sum with the clamped joint two
  always_comb begin
    logic signed [33:0] mn, mx, rel, lhs;
    clamp_any = 1'b0;
    for (int i = 0; i < JOINTS; i++) begin
      mn  = {{2{lim_r[i][15]}}, lim_r[i][15:0], 16'b0};
      mx  = {{2{lim_r[i][31]}}, lim_r[i][31:16], 16'b0};
      rel = (i == 2) ? 34'(ccl[1]) : 34'sd0;
      lhs = 34'(cmd_r[i]) + rel;
      ccl[i] = cmd_r[i];
      if (mn != mx) begin
        if (lhs < mn - CLAMP_TOL) begin
          ccl[i] = sat32(40'(mn - rel));
          clamp_any = 1'b1;
        end else if (lhs > mx + CLAMP_TOL) begin
          ccl[i] = sat32(40'(mx - rel));
          clamp_any = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < JOINTS; i++) lim_r[i] <= '0;
      tick_r <= TICK_RESET;
    end else if (cfg_we) begin
      if (cfg_index < 3'(JOINTS)) lim_r[cfg_index] <= cfg_data;
      else if (cfg_index == REG_TICK) tick_r <= cfg_data[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      rv_r        <= '0;
      wjm_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < JOINTS; i++) cmd_r[i] <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_CLAMP) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            fb_r[0] <= in_feedback_first;
            fb_r[1] <= in_feedback_second;
            fb_r[2] <= in_feedback_third;
            fb_r[3] <= in_feedback_fourth;
            fb_r[4] <= in_feedback_fifth;
            fb_r[5] <= in_feedback_sixth;
            axis_r  <= in_jog_axis;
            jog_r   <= in_jog_speed;
            ovr_r   <= ovr_c;
            mode_r  <= in_mode_select;
            rs_r    <= in_resync;
            start_r <= 1'b1;
            state_r <= S_LANE;
          end
        end
        S_LANE: begin
          start_r <= 1'b0;
          if (!start_r && (&ldone)) state_r <= S_M1;
        end
        S_M1: begin
          if (mode_r == MODE_JOINT && (!wjm_r || rs_r)) begin
            for (int i = 0; i < JOINTS; i++) cmd_r[i] <= fb_r[i];
            rv_r <= '0;
          end
          if (mode_r != MODE_NONE) wjm_r <= (mode_r == MODE_JOINT);
          m1_r    <= $signed({1'b0, vel_j}) * jog_r;
          m2_r    <= ovr_r * scale;
          accdt_r <= acc_j * dt;
          state_r <= S_M2;
        end
        S_M2: begin
          p_r     <= m1_r * $signed({1'b0, m2_r});
          state_r <= S_RAMP;
        end
        S_RAMP: begin
          if (jogging) rv_r <= rv_nxt;
          vcap_r  <= vcap_nxt;
          state_r <= S_MOVE;
        end
        S_MOVE: begin
          mv_r    <= vcap_r * $signed({1'b0, dt});
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (rs_r) for (int i = 0; i < JOINTS; i++) cmd_r[i] <= fb_r[i];
          else if (jogging) cmd_r[axis_r] <= move_nxt;
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          // hold until the previous result is taken
          if (!out_valid_r || !out_stall) begin
            for (int i = 0; i < JOINTS; i++) begin
              cmd_r[i]     <= ccl[i];
              out_cmd_r[i] <= ccl[i];
            end
            out_clamped_r <= clamp_any;
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_command_first  = out_cmd_r[0];
  assign out_command_second = out_cmd_r[1];
  assign out_command_third  = out_cmd_r[2];
  assign out_command_fourth = out_cmd_r[3];
  assign out_command_fifth  = out_cmd_r[4];
  assign out_command_sixth  = out_cmd_r[5];
  assign out_clamped        = out_clamped_r;

endmodule

@@ tb/joint_jog_soft_limiter_top_tb.sv @@
module joint_jog_soft_limiter_top_tb;

  typedef enum logic [2:0] {
    REG_LIM_J1, REG_LIM_J2, REG_LIM_J3, REG_LIM_J4, REG_LIM_J5, REG_LIM_J6, REG_TICK
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0, MODE_OTHER = 2'd1, MODE_JOINT = 2'd2, MODE_SPARE = 2'd3
  } jog_mode_t;

  localparam longint CLAMP_TOL = 268435;
  localparam longint OVR_LO = 33;
  localparam longint OVR_HI = 32768;
  localparam logic [47:0] TICK_DEFAULT = 48'd140737492650295;

  typedef struct packed {
    logic [5:0][31:0] fb;
    logic [2:0]       axis;
    logic [15:0]      jog;
    logic [15:0]      ovr;
    logic [1:0]       mode;
    logic             resync;
  } tick_in_t;

  typedef struct packed {
    logic [5:0][31:0] cmd;
    logic             clamped;
  } tick_res_t;

  typedef struct packed {
    tick_in_t  item;
    logic      has_exp;
    tick_res_t exp;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] in_fb [6];
  logic [2:0] in_jog_axis;
  logic signed [15:0] in_jog_speed;
  logic [15:0] in_override_fraction;
  logic [1:0] in_mode_select;
  logic in_resync;
  logic signed [31:0] out_cmd [6];
  logic out_clamped;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  joint_jog_soft_limiter_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_feedback_first(in_fb[0]), .in_feedback_second(in_fb[1]),
    .in_feedback_third(in_fb[2]), .in_feedback_fourth(in_fb[3]),
    .in_feedback_fifth(in_fb[4]), .in_feedback_sixth(in_fb[5]),
    .in_jog_axis(in_jog_axis), .in_jog_speed(in_jog_speed),
    .in_override_fraction(in_override_fraction), .in_mode_select(in_mode_select),
    .in_resync(in_resync),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_command_first(out_cmd[0]), .out_command_second(out_cmd[1]),
    .out_command_third(out_cmd[2]), .out_command_fourth(out_cmd[3]),
    .out_command_fifth(out_cmd[4]), .out_command_sixth(out_cmd[5]),
    .out_clamped(out_clamped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // joint state mirror
  logic [63:0] lim_regs [6];
  logic [47:0] tick_cfg;
  int          cmd_pos [6];
  int          jog_vel;
  bit          in_joint_mode;

  tick_res_t   pending_cmds [$];
  bit          failed;
  int          tx_idle, rx_idle;
  int          hold_left;
  bit          hold_req;
  stim_row_t   dir_rows [$];

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic longint pos_min(int j);
    return longint'($signed(lim_regs[j][15:0])) * 65536;
  endfunction

  function automatic longint pos_max(int j);
    return longint'($signed(lim_regs[j][31:16])) * 65536;
  endfunction

  function automatic longint unsigned vel_lim(int j);
    return lim_regs[j][47:32];
  endfunction

  function automatic longint unsigned acc_lim(int j);
    return lim_regs[j][63:48];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // fastest speed that still brakes to a stop within distance d
  function automatic longint brake_speed(longint d, int j);
    longint unsigned v, x;
    if (d < 0) return 0;
    v = vel_lim(j) << 12;
    x = (2 * acc_lim(j) * longint'(d)) << 12;
    if (x > v * v) return longint'(v);
    return longint'(int_sqrt(x));
  endfunction

  function automatic longint min2(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic tick_res_t predict_tick(tick_in_t it);
    longint fb [6], c [6], dmin [6], dmax [6], pos_ok [6], neg_ok [6];
    longint ovr, jog, sum, p, want, stp, diff, v, rel, mn, mx;
    longint unsigned dt, scale;
    int j;
    tick_res_t r;
    r.clamped = 0;
    dt = tick_cfg[31:0];
    scale = tick_cfg[47:32];
    ovr = it.ovr;
    if (ovr < OVR_LO) ovr = OVR_LO;
    if (ovr > OVR_HI) ovr = OVR_HI;
    jog = longint'($signed(it.jog));
    for (int i = 0; i < 6; i++) begin
      fb[i] = longint'($signed(it.fb[i]));
      c[i] = cmd_pos[i];
      dmin[i] = 0;
      dmax[i] = 0;
    end
    sum = c[1] + c[2];
    dmin[0] = c[0] - pos_min(0);
    dmax[0] = pos_max(0) - c[0];
    dmin[1] = min2(c[1] - pos_min(1), sum - pos_min(2));
    dmax[1] = min2(pos_max(1) - c[1], pos_max(2) - sum);
    dmin[2] = sum - pos_min(2);
    dmax[2] = pos_max(2) - sum;
    dmin[4] = c[4] - pos_min(4);
    dmax[4] = pos_max(4) - c[4];
    for (int i = 0; i < 6; i++) begin
      if (i == 3 || i == 5) begin
        pos_ok[i] = longint'(vel_lim(i) << 12);
        neg_ok[i] = pos_ok[i];
      end else begin
        pos_ok[i] = brake_speed(dmax[i], i);
        neg_ok[i] = brake_speed(dmin[i], i);
      end
    end
    if (it.mode == MODE_JOINT) begin
      if (!in_joint_mode || it.resync) begin
        for (int i = 0; i < 6; i++) c[i] = fb[i];
        jog_vel = 0;
      end
      if (it.axis < 6) begin
        j = it.axis;
        p = longint'(vel_lim(j)) * jog * ovr * longint'(scale);
        want = p >>> 33;
        stp = longint'((acc_lim(j) * dt) >> 16);
        diff = want - longint'(jog_vel);
        if (diff > stp) v = longint'(jog_vel) + stp;
        else if (diff < -stp) v = longint'(jog_vel) - stp;
        else v = want;
        jog_vel = sat32(v);
        v = jog_vel;
        // only the applied step is capped, the ramp keeps its own value
        if (v < 0) begin
          if (v < -neg_ok[j]) v = -neg_ok[j];
        end else if (v > pos_ok[j]) begin
          v = pos_ok[j];
        end
        c[j] = sat32(c[j] + ((v * longint'(dt)) >>> 28));
      end
    end
    if (it.mode != MODE_IDLE) in_joint_mode = (it.mode == MODE_JOINT);
    if (it.resync) for (int i = 0; i < 6; i++) c[i] = fb[i];
    for (int i = 0; i < 6; i++) begin
      rel = (i == 2) ? c[1] : 0;
      mn = pos_min(i);
      mx = pos_max(i);
      if (mn != mx) begin
        if (c[i] + rel < mn - CLAMP_TOL) begin
          c[i] = sat32(mn - rel);
          r.clamped = 1;
        end else if (c[i] + rel > mx + CLAMP_TOL) begin
          c[i] = sat32(mx - rel);
          r.clamped = 1;
        end
      end
    end
    for (int i = 0; i < 6; i++) begin
      cmd_pos[i] = sat32(c[i]);
      r.cmd[i] = cmd_pos[i];
    end
    return r;
  endfunction

  task automatic send_tick(stim_row_t row);
    tick_res_t res;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    for (int i = 0; i < 6; i++) in_fb[i] <= row.item.fb[i];
    in_jog_axis <= row.item.axis;
    in_jog_speed <= row.item.jog;
    in_override_fraction <= row.item.ovr;
    in_mode_select <= row.item.mode;
    in_resync <= row.item.resync;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    res = predict_tick(row.item);
    pending_cmds.push_back(row.has_exp ? row.exp : res);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_TICK) tick_cfg = val[47:0];
    else lim_regs[idx] = val;
  endtask

  // min/max in Q4.12, velocity Q4.12, accel Q8.8
  function automatic logic [63:0] pack_lim(int mn, int mx, int vel, int acc);
    return {acc[15:0], vel[15:0], mx[15:0], mn[15:0]};
  endfunction

  task automatic load_sane_limits();
    for (int j = 0; j < 6; j++)
      write_reg(cfg_reg_t'(j), pack_lim(-8192, 8192, 4096, 2560));
    write_reg(REG_TICK, TICK_DEFAULT);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic load_random_limits();
    int mn, mx;
    for (int j = 0; j < 6; j++) begin
      mn = -int'($urandom_range(16384, 1024));
      mx = $urandom_range(16384, 1024);
      if ($urandom_range(5) == 0) write_reg(cfg_reg_t'(j), {$urandom, $urandom});
      else write_reg(cfg_reg_t'(j), pack_lim(mn, mx, $urandom_range(65535), $urandom_range(65535)));
    end
    write_reg(REG_TICK, {16'($urandom), 32'($urandom_range(40000000, 400000))});
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic load_flat_limits(logic [63:0] lim, logic [47:0] tick);
    for (int j = 0; j < 6; j++) write_reg(cfg_reg_t'(j), lim);
    write_reg(REG_TICK, {16'd0, tick});
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic tick_in_t rand_tick();
    tick_in_t it;
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(7) == 0) it.fb[i] = $urandom;
      else it.fb[i] = int'($urandom_range(1342177280)) - 671088640;
    end
    it.axis = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
    it.jog = 16'($urandom);
    it.ovr = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768, 33));
    it.mode = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : MODE_JOINT;
    it.resync = ($urandom_range(31) == 0);
    return it;
  endfunction

  task automatic run_random(int n);
    stim_row_t row;
    row.has_exp = 0;
    row.exp = '0;
    repeat (n) begin
      row.item = rand_tick();
      send_tick(row);
    end
  endtask

  function automatic stim_row_t mk_row(logic [31:0] f, logic [2:0] axis, logic [15:0] jog,
                                       logic [15:0] ovr, jog_mode_t mode, logic rs);
    stim_row_t row;
    for (int i = 0; i < 6; i++) row.item.fb[i] = f + 32'(i) * 32'h0100_0000;
    row.item.axis = axis;
    row.item.jog = jog;
    row.item.ovr = ovr;
    row.item.mode = mode;
    row.item.resync = rs;
    row.has_exp = 0;
    row.exp = '0;
    return row;
  endfunction

  // result check
  always @(posedge clk) begin
    tick_res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("result with no item pending");
        failed = 1;
      end else begin
        e = pending_cmds.pop_front();
        for (int i = 0; i < 6; i++)
          if (out_cmd[i] !== e.cmd[i]) begin
            $error("command[%0d] exp %0d got %0d", i, $signed(e.cmd[i]), out_cmd[i]);
            failed = 1;
          end
        if (out_clamped !== e.clamped) begin
          $error("clamped exp %0b got %0b", e.clamped, out_clamped);
          failed = 1;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  initial begin
    stim_row_t row;
    failed = 0;
    hold_req = 0;
    hold_left = 0;
    tx_idle = 0;
    rx_idle = 0;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    for (int i = 0; i < 6; i++) in_fb[i] = 0;
    in_jog_axis = 0;
    in_jog_speed = 0;
    in_override_fraction = 0;
    in_mode_select = 0;
    in_resync = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    for (int j = 0; j < 6; j++) lim_regs[j] = 0;
    tick_cfg = TICK_DEFAULT;
    for (int j = 0; j < 6; j++) cmd_pos[j] = 0;
    jog_vel = 0;
    in_joint_mode = 0;

    // limits all zero after reset: nothing jogs and nothing clamps
    row = mk_row(32'h0, 3'd0, 16'h7fff, 16'h8000, MODE_IDLE, 0);
    row.has_exp = 1;
    row.exp = '0;
    dir_rows.push_back(row);
    row = mk_row(32'h0, 3'd7, 16'h0, 16'h0, MODE_IDLE, 1);
    row.item.fb = {32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1, 32'h80000000, 32'h7fffffff};
    row.has_exp = 1;
    row.exp.cmd = row.item.fb;
    row.exp.clamped = 0;
    dir_rows.push_back(row);

    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_rows[k]) send_tick(dir_rows[k]);
    wait_drained();

    load_sane_limits();
    dir_rows.delete();
    dir_rows.push_back(mk_row(32'h0, 3'd0, 16'h7fff, 16'h8000, MODE_JOINT, 0));
    for (int a = 0; a < 6; a++) begin
      dir_rows.push_back(mk_row(32'h0, 3'(a), 16'h7fff, 16'h8000, MODE_JOINT, 0));
      dir_rows.push_back(mk_row(32'h0, 3'(a), 16'h8000, 16'hffff, MODE_JOINT, 0));
    end
    dir_rows.push_back(mk_row(32'h0, 3'd6, 16'h7fff, 16'h0, MODE_JOINT, 0));
    dir_rows.push_back(mk_row(32'h0, 3'd7, 16'h7fff, 16'h0, MODE_JOINT, 0));
    dir_rows.push_back(mk_row(32'h1000_0000, 3'd1, 16'h4000, 16'd0, MODE_JOINT, 1));
    dir_rows.push_back(mk_row(32'h7000_0000, 3'd0, 16'h4000, 16'd32, MODE_OTHER, 0));
    dir_rows.push_back(mk_row(32'h9000_0000, 3'd0, 16'h4000, 16'd33, MODE_SPARE, 1));
    dir_rows.push_back(mk_row(32'h2800_0000, 3'd2, 16'h7fff, 16'h8000, MODE_JOINT, 0));
    dir_rows.push_back(mk_row(32'h0, 3'd4, 16'h0001, 16'h8001, MODE_IDLE, 0));
    foreach (dir_rows[k]) send_tick(dir_rows[k]);
    wait_drained();

    tx_idle = 22;
    rx_idle = 58;
    hold_req = 1;
    run_random(360);
    wait_drained();

    load_random_limits();
    tx_idle = 58;
    rx_idle = 22;
    run_random(360);
    wait_drained();

    tx_idle = 0;
    rx_idle = 0;
    load_flat_limits(64'hffff_ffff_ffff_ffff, 48'hffff_ffff_ffff);
    run_random(100);
    wait_drained();
    load_flat_limits(64'h0, 48'h0);
    run_random(100);
    wait_drained();
    load_sane_limits();
    run_random(200);
    wait_drained();

    if (!failed) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
